[rtl/running_moment_statistics_macros.svh]
// Assertion macros for the running moment statistics RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef RUNNING_MOMENT_STATISTICS_MACROS_SVH
`define RUNNING_MOMENT_STATISTICS_MACROS_SVH

// ante |-> cons on the rising edge of clk, off while rst is high
`define RMS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// ante |=> cons on the rising edge of clk, off while rst is high
`define RMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rms_pkg.sv]
// Shared types and constants for the running moment statistics block.
// No dependencies; imported by every module of the block.
package rms_pkg;

   localparam int SAMPLE_W = 24;
   localparam int COUNT_W  = 16;
   localparam int SUM_W    = 40;
   localparam int SUM_SQ_W = 64;
   localparam int STD_W    = 23;
   localparam int OP_W     = 2;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_MERGE  = 2'd1;
   localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [OP_W-1:0]            operation;
      logic signed [SAMPLE_W-1:0] sample;
      logic [COUNT_W-1:0]         other_count;
      logic signed [SUM_W-1:0]    other_sum;
      logic [SUM_SQ_W-1:0]        other_sum_sq;
      logic signed [SAMPLE_W-1:0] other_min;
      logic signed [SAMPLE_W-1:0] other_max;
   } req_word_type;

   typedef struct packed {
      logic [STD_W-1:0]           std_dev;
      logic signed [SAMPLE_W-1:0] min_value;
      logic signed [SAMPLE_W-1:0] max_value;
      logic [COUNT_W-1:0]         sample_count;
      logic signed [SUM_W-1:0]    total_sum;
      logic [SUM_SQ_W-1:0]        total_sum_sq;
      logic                       stats_valid;
      logic                       saturated;
   } rsp_word_type;

   typedef struct packed {
      logic         is_report;
      req_word_type word;
   } queue_entry_type;

   // accumulator state captured for one report
   typedef struct packed {
      logic [COUNT_W-1:0]         count;
      logic signed [SUM_W-1:0]    sum;
      logic [SUM_SQ_W-1:0]        sum_sq;
      logic signed [SAMPLE_W-1:0] min_value;
      logic signed [SAMPLE_W-1:0] max_value;
      logic                       saturated;
   } snap_type;

endpackage

[rtl/rms_stream_if.sv]
// Valid/ready stream channel carrying one word of any packed type.
// No dependencies; the word type comes in as a parameter.
interface rms_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/rms_front.sv]
// Front end: takes request words, drops unused operation codes and queues
// the rest for the accumulator. Uses rms_pkg and rms_stream_if.
module rms_front (
   input  logic                     clock,
   input  logic                     reset,
   rms_stream_if.sink               req_ch,
   output logic                     head_valid,
   output rms_pkg::queue_entry_type head_entry,
   input  logic                     head_pop
);
   import rms_pkg::*;

   queue_entry_type   entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;
   logic              keep;
   logic              is_report;
   logic              push;
   logic              pop;

   always_comb begin
      keep      = 1'b0;
      is_report = 1'b0;
      unique case (req_ch.payload.operation) inside
         OP_ADD, OP_MERGE: keep = 1'b1;
         OP_REPORT: begin
            keep      = 1'b1;
            is_report = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_ch.ready = (fill_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready && keep;
   assign pop          = head_pop && head_valid;

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign fill_in   = fill_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);

   assign head_valid = (fill_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= '{is_report: is_report, word: req_ch.payload};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

[rtl/rms_accum.sv]
// Back end accumulator: squares samples, commits count/sum/sum of squares/
// min/max with saturation, and snapshots the state for reports. Uses rms_pkg.
`include "running_moment_statistics_macros.svh"

module rms_accum #(
   parameter int SAMPLE_BITS = 24,
   parameter int COUNT_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  rms_pkg::queue_entry_type head_entry,
   output logic                     head_pop,
   output logic                     snap_valid,
   output rms_pkg::snap_type        snap,
   input  logic                     snap_ready
);
   import rms_pkg::*;

   localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
   localparam int SUM_WIDE = SUM_W + 2;
   localparam logic signed [SUM_WIDE-1:0] SUM_MAX_WIDE =
      (SUM_WIDE'(1) <<< (SUM_BITS - 1)) - SUM_WIDE'(1);
   localparam logic signed [SUM_WIDE-1:0] SUM_MIN_WIDE = -SUM_MAX_WIDE - SUM_WIDE'(1);
   localparam logic signed [SUM_BITS-1:0] SUM_MAX = SUM_MAX_WIDE[SUM_BITS-1:0];
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = SUM_MIN_WIDE[SUM_BITS-1:0];
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   req_word_type                   word;
   logic                           head_is_report;
   logic                           is_add;
   logic [SAMPLE_BITS-1:0]         samp_bits;
   logic signed [SAMPLE_BITS-1:0]  samp;
   logic [SAMPLE_BITS-1:0]         samp_mag;
   logic [2*SAMPLE_BITS-1:0]       samp_sq;

   logic                           s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_BITS-1:0]  s1_lo_ff, s1_lo_in;
   logic signed [SAMPLE_BITS-1:0]  s1_hi_ff, s1_hi_in;
   logic [COUNT_BITS-1:0]          s1_dcount_ff, s1_dcount_in;
   logic signed [SUM_W-1:0]        s1_dsum_ff, s1_dsum_in;
   logic [SUM_SQ_W-1:0]            s1_dsq_ff, s1_dsq_in;

   logic [COUNT_BITS-1:0]          count_ff, count_in;
   logic signed [SUM_BITS-1:0]     sum_ff, sum_in;
   logic [SUM_SQ_W-1:0]            sum_sq_ff, sum_sq_in;
   logic signed [SAMPLE_BITS-1:0]  min_ff, min_in;
   logic signed [SAMPLE_BITS-1:0]  max_ff, max_in;
   logic                           sat_ff, sat_in;

   logic [COUNT_BITS:0]            count_sum;
   logic signed [SUM_WIDE-1:0]     sum_wide;
   logic [SUM_SQ_W:0]              sq_sum;

   // issue side
   assign word           = head_entry.word;
   assign head_is_report = head_entry.is_report;
   assign is_add         = (word.operation == OP_ADD);

   // a report waits until the add/merge in flight has landed
   assign snap_valid = head_valid && head_is_report && !s1_valid_ff;
   assign head_pop   = head_valid && (!head_is_report || (!s1_valid_ff && snap_ready));

   assign samp_bits = word.sample[SAMPLE_BITS-1:0];
   assign samp      = samp_bits;
   assign samp_mag  = samp_bits[SAMPLE_BITS-1] ? (~samp_bits + 1'b1) : samp_bits;
   assign samp_sq   = samp_mag * samp_mag;

   assign s1_valid_in  = head_valid && !head_is_report;
   assign s1_lo_in     = is_add ? samp : word.other_min[SAMPLE_BITS-1:0];
   assign s1_hi_in     = is_add ? samp : word.other_max[SAMPLE_BITS-1:0];
   assign s1_dsum_in   = is_add ? SUM_W'(samp) : word.other_sum;
   assign s1_dsq_in    = is_add ? SUM_SQ_W'(samp_sq) : word.other_sum_sq;
   assign s1_dcount_in = is_add ? COUNT_BITS'(1) : word.other_count[COUNT_BITS-1:0];

   // commit side
   assign count_sum = {1'b0, count_ff} + {1'b0, s1_dcount_ff};
   assign sum_wide  = SUM_WIDE'(sum_ff) + SUM_WIDE'(s1_dsum_ff);
   assign sq_sum    = {1'b0, sum_sq_ff} + {1'b0, s1_dsq_ff};

   always_comb begin
      count_in  = count_ff;
      sum_in    = sum_ff;
      sum_sq_in = sum_sq_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      sat_in    = sat_ff;
      if (s1_valid_ff) begin
         if (count_sum[COUNT_BITS]) begin
            count_in = '1;
            sat_in   = 1'b1;
         end else begin
            count_in = count_sum[COUNT_BITS-1:0];
         end
         if (sum_wide > SUM_MAX_WIDE) begin
            sum_in = SUM_MAX;
            sat_in = 1'b1;
         end else if (sum_wide < SUM_MIN_WIDE) begin
            sum_in = SUM_MIN;
            sat_in = 1'b1;
         end else begin
            sum_in = sum_wide[SUM_BITS-1:0];
         end
         if (sq_sum[SUM_SQ_W]) begin
            sum_sq_in = '1;
            sat_in    = 1'b1;
         end else begin
            sum_sq_in = sq_sum[SUM_SQ_W-1:0];
         end
         if (s1_lo_ff < min_ff) begin
            min_in = s1_lo_ff;
         end
         if (s1_hi_ff > max_ff) begin
            max_in = s1_hi_ff;
         end
      end
   end

   assign snap.count     = COUNT_W'(count_ff);
   assign snap.sum       = SUM_W'(sum_ff);
   assign snap.sum_sq    = sum_sq_ff;
   assign snap.min_value = SAMPLE_W'(min_ff);
   assign snap.max_value = SAMPLE_W'(max_ff);
   assign snap.saturated = sat_ff;

   always_ff @(posedge clock) begin
      s1_lo_ff     <= s1_lo_in;
      s1_hi_ff     <= s1_hi_in;
      s1_dcount_ff <= s1_dcount_in;
      s1_dsum_ff   <= s1_dsum_in;
      s1_dsq_ff    <= s1_dsq_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         count_ff    <= '0;
         sum_ff      <= '0;
         sum_sq_ff   <= '0;
         min_ff      <= SAMPLE_MAX;
         max_ff      <= SAMPLE_MIN;
         sat_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         sum_sq_ff   <= sum_sq_in;
         min_ff      <= min_in;
         max_ff      <= max_in;
         sat_ff      <= sat_in;
      end
   end

   `RMS_ASSERT_NEXT(a_sat_sticky, clock, reset, sat_ff, sat_ff, "saturation flag dropped")
   `RMS_ASSERT_NEXT(a_count_nonzero, clock, reset, count_ff != '0, count_ff != '0, "count fell to zero")
   `RMS_ASSERT_NEXT(a_idle_hold, clock, reset, !s1_valid_ff, $stable(count_ff) && $stable(sum_ff) && $stable(sum_sq_ff), "totals moved with no commit")

endmodule

[rtl/rms_stats.sv]
// Report unit: n*sumsq - sum^2 on one shared 32x32 multiplier, restoring
// divide by n^2, digit-by-digit square root, and the result register.
// Uses rms_pkg and rms_stream_if.
`include "running_moment_statistics_macros.svh"

module rms_stats (
   input  logic              clock,
   input  logic              reset,
   input  logic              snap_valid,
   input  rms_pkg::snap_type snap,
   output logic              snap_ready,
   rms_stream_if.source      rsp_ch
);
   import rms_pkg::*;

   localparam int MUL_W      = 32;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int QUO_W      = 80;
   localparam int ACC_W      = QUO_W + 2;
   localparam int DIVISOR_W  = 32;
   localparam int ROOT_W     = 32;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int REM_W      = ROOT_W + 2;
   localparam int DIV_STEPS  = QUO_W;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_ROOT = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   // multiply schedule: n*sumsq in two halves, |sum|^2 in three, then n*n
   localparam logic [STEP_W-1:0] STEP_NS0   = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_NS1   = STEP_W'(1);
   localparam logic [STEP_W-1:0] STEP_M00   = STEP_W'(2);
   localparam logic [STEP_W-1:0] STEP_M01   = STEP_W'(3);
   localparam logic [STEP_W-1:0] STEP_M11   = STEP_W'(4);
   localparam logic [STEP_W-1:0] STEP_NN    = STEP_W'(5);
   localparam logic [STEP_W-1:0] STEP_DRAIN = STEP_W'(6);
   localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(DIV_STEPS - 1);
   localparam logic [STEP_W-1:0] ROOT_LAST  = STEP_W'(ROOT_STEPS - 1);

   logic [2:0]           state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   snap_type             snap_ff, snap_in;
   logic [SUM_W-1:0]     mag_ff, mag_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]     dq_ff, dq_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_word_ff, rsp_word_in;

   logic [SUM_W-1:0]     sum_bits;
   logic [SUM_W-1:0]     snap_mag;
   logic [MUL_W-1:0]     mul_a, mul_b;
   logic [ACC_W-1:0]     prod_ext;
   logic [ACC_W-1:0]     acc_term;
   logic                 acc_pos;
   logic [DIVISOR_W:0]   div_trial, div_rem;
   logic                 div_ge;
   logic [REM_W+1:0]     root_trial, root_test, root_rem;
   logic                 root_ge;
   logic [STD_W-1:0]     std_val;

   assign sum_bits = snap.sum;
   assign snap_mag = sum_bits[SUM_W-1] ? (~sum_bits + 1'b1) : sum_bits;

   always_comb begin
      unique case (step_ff)
         STEP_NS0: begin
            mul_a = MUL_W'(snap_ff.count);
            mul_b = snap_ff.sum_sq[MUL_W-1:0];
         end
         STEP_NS1: begin
            mul_a = MUL_W'(snap_ff.count);
            mul_b = snap_ff.sum_sq[PROD_W-1:MUL_W];
         end
         STEP_M00: begin
            mul_a = mag_ff[MUL_W-1:0];
            mul_b = mag_ff[MUL_W-1:0];
         end
         STEP_M01: begin
            mul_a = mag_ff[MUL_W-1:0];
            mul_b = MUL_W'(mag_ff[SUM_W-1:MUL_W]);
         end
         STEP_M11: begin
            mul_a = MUL_W'(mag_ff[SUM_W-1:MUL_W]);
            mul_b = MUL_W'(mag_ff[SUM_W-1:MUL_W]);
         end
         STEP_NN: begin
            mul_a = MUL_W'(snap_ff.count);
            mul_b = MUL_W'(snap_ff.count);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_ext = ACC_W'(prod_ff);

   // product registered last cycle lands in the accumulator this cycle
   always_comb begin
      unique case (step_ff)
         STEP_NS1: acc_term = prod_ext;
         STEP_M00: acc_term = prod_ext << MUL_W;
         STEP_M01: acc_term = -prod_ext;
         STEP_M11: acc_term = -(prod_ext << (MUL_W + 1));
         STEP_NN:  acc_term = -(prod_ext << (2 * MUL_W));
         default:  acc_term = '0;
      endcase
   end

   assign acc_pos = !acc_ff[ACC_W-1] && (acc_ff != '0);

   assign div_trial = {rem_ff[DIVISOR_W-1:0], dq_ff[QUO_W-1]};
   assign div_ge    = (div_trial >= {1'b0, divisor_ff});
   assign div_rem   = div_ge ? div_trial - {1'b0, divisor_ff} : div_trial;

   assign root_trial = {rem_ff, dq_ff[RAD_W-1 -: 2]};
   assign root_test  = {2'b00, root_ff, 2'b01};
   assign root_ge    = (root_trial >= root_test);
   assign root_rem   = root_ge ? root_trial - root_test : root_trial;

   assign std_val = (|root_ff[ROOT_W-1:STD_W]) ? '1 : root_ff[STD_W-1:0];

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      snap_in      = snap_ff;
      mag_in       = mag_ff;
      acc_in       = acc_ff;
      divisor_in   = divisor_ff;
      rem_in       = rem_ff;
      dq_in        = dq_ff;
      root_in      = root_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_word_in  = rsp_word_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (snap_valid) begin
               snap_in  = snap;
               mag_in   = snap_mag;
               acc_in   = '0;
               step_in  = STEP_NS0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in  = acc_ff + acc_term;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_DRAIN) begin
               divisor_in = prod_ff[DIVISOR_W-1:0];
               dq_in      = acc_ff[QUO_W-1:0];
               rem_in     = '0;
               root_in    = '0;
               step_in    = '0;
               // nothing to divide when the variance is not positive
               state_in   = acc_pos ? ST_DIV : ST_DONE;
            end
         end
         ST_DIV: begin
            rem_in  = REM_W'(div_rem[DIVISOR_W-1:0]);
            dq_in   = {dq_ff[QUO_W-2:0], div_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            rem_in  = root_rem[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], root_ge};
            dq_in   = dq_ff << 2;
            step_in = step_ff + 1'b1;
            if (step_ff == ROOT_LAST) begin
               step_in  = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.std_dev      = std_val;
               rsp_word_in.min_value    = snap_ff.min_value;
               rsp_word_in.max_value    = snap_ff.max_value;
               rsp_word_in.sample_count = snap_ff.count;
               rsp_word_in.total_sum    = snap_ff.sum;
               rsp_word_in.total_sum_sq = snap_ff.sum_sq;
               rsp_word_in.stats_valid  = (snap_ff.count != '0);
               rsp_word_in.saturated    = snap_ff.saturated;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign snap_ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_word_ff;

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      snap_ff     <= snap_in;
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      dq_ff       <= dq_in;
      root_ff     <= root_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `RMS_ASSERT_NOW(a_divisor_nonzero, clock, reset, state_ff == ST_DIV, divisor_ff != '0, "divide with zero divisor")
   `RMS_ASSERT_NOW(a_empty_std, clock, reset, rsp_valid_ff && !rsp_word_ff.stats_valid, rsp_word_ff.std_dev == '0, "empty report with nonzero deviation")
   `RMS_ASSERT_NEXT(a_snap_start, clock, reset, snap_valid && snap_ready, state_ff == ST_MUL && step_ff == STEP_NS0, "snapshot taken without starting")

endmodule

[rtl/running_moment_statistics.sv]
// Adds and merges commit via the queue and issue register, one per cycle while no report
// waits at the queue head. A report takes 7 steps on one 32x32 multiplier, then, if the
// variance is positive, 80 one-bit divide steps and 32 square root steps, then the result
// register. The report unit serves one report at a time; adds keep flowing meanwhile
// until the 4-entry queue backs up behind a waiting report. Reset (synchronous) empties
// the queue and sets count/sums to zero, min to most positive, max to most negative.
module running_moment_statistics #(
   parameter int SAMPLE_BITS = 24,
   parameter int COUNT_BITS  = 16
) (
   input  logic         clock,
   input  logic         reset,
   rms_stream_if.sink   req_ch,
   rms_stream_if.source rsp_ch
);
   import rms_pkg::*;

   logic            head_valid;
   logic            head_pop;
   queue_entry_type head_entry;
   logic            snap_valid;
   logic            snap_ready;
   snap_type        snap;

   rms_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .head_pop   (head_pop)
   );

   rms_accum #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .head_pop   (head_pop),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_ready (snap_ready)
   );

   rms_stats u_stats (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_ready (snap_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule

[bench/tb_top.sv]
// Testbench for running_moment_statistics: directed and random words on the request channel,
// with every report checked field by field against an accumulator kept in the bench.
// Depends on rms_pkg, rms_stream_if and the block RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rms_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_LO = -SAMPLE_HI - 1;
   localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
   localparam longint SUM_LO = -SUM_HI - 1;
   localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
   localparam logic [STD_W-1:0] STD_TOP = '1;
   localparam int RANDOM_WORDS = 414;
   localparam int HOLD_AT = 12;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 50;
   localparam int CYCLE_LIMIT = 200000;

   logic clock;
   logic reset;

   rms_stream_if #(.payload_type(req_word_type)) req_ch ();
   rms_stream_if #(.payload_type(rsp_word_type)) rsp_ch ();

   running_moment_statistics uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   req_word_type words_to_send[$];
   rsp_word_type pending_reports[$];

   // accumulator as the block should hold it
   logic [COUNT_W-1:0] acc_count = '0;
   longint acc_sum = 0;
   logic [SUM_SQ_W-1:0] acc_sum_sq = '0;
   longint acc_min = SAMPLE_HI;
   longint acc_max = SAMPLE_LO;
   logic acc_sat = 1'b0;

   int total_words = 0;
   int words_in = 0;
   int reports_in = 0;
   int results_seen = 0;
   int hold_left = 0;
   int errors = 0;
   int cycles = 0;

   always #1 clock = ~clock;

   // all fields random, operation forced
   function automatic req_word_type scrambled(input logic [OP_W-1:0] op);
      req_word_type w;
      w.operation    = op;
      w.sample       = SAMPLE_W'($urandom);
      w.other_count  = COUNT_W'($urandom);
      w.other_sum    = SUM_W'({$urandom, $urandom});
      w.other_sum_sq = {$urandom, $urandom};
      w.other_min    = SAMPLE_W'($urandom);
      w.other_max    = SAMPLE_W'($urandom);
      return w;
   endfunction

   function automatic req_word_type add_word(input longint v);
      req_word_type w;
      w = scrambled(OP_ADD);
      w.sample = v[SAMPLE_W-1:0];
      return w;
   endfunction

   function automatic req_word_type merge_word(input int unsigned cnt, input longint s,
                                               input logic [SUM_SQ_W-1:0] sq,
                                               input longint mn, input longint mx);
      req_word_type w;
      w = scrambled(OP_MERGE);
      w.other_count  = cnt[COUNT_W-1:0];
      w.other_sum    = s[SUM_W-1:0];
      w.other_sum_sq = sq;
      w.other_min    = mn[SAMPLE_W-1:0];
      w.other_max    = mx[SAMPLE_W-1:0];
      return w;
   endfunction

   // floor(sqrt((n*sumsq - sum^2) / n^2)), zero when not positive, clamped to the output
   function automatic logic [STD_W-1:0] deviation_of(input logic [COUNT_W-1:0] n,
                                                     input longint s,
                                                     input logic [SUM_SQ_W-1:0] sq);
      logic [127:0] lhs, rhs, quot;
      logic [63:0] mag, v, res, probe;
      if (n == 0) return '0;
      mag = (s < 0) ? -s : s;
      lhs = 128'(n) * 128'(sq);
      rhs = 128'(mag) * 128'(mag);
      if (lhs <= rhs) return '0;
      quot = (lhs - rhs) / 128'(n);
      quot = quot / 128'(n);
      v = quot[63:0];
      res = '0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > v) probe = probe >> 2;
      while (probe != 0) begin
         if (v >= res + probe) begin
            v = v - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      if (res > 64'(STD_TOP)) return STD_TOP;
      return res[STD_W-1:0];
   endfunction

   task automatic accumulate(input logic [COUNT_W:0] n_add, input longint s_add,
                             input logic [SUM_SQ_W-1:0] q_add);
      logic [COUNT_W:0] n_new;
      logic [SUM_SQ_W:0] q_new;
      longint s_new;
      n_new = {1'b0, acc_count} + n_add;
      if (n_new[COUNT_W]) begin
         acc_count = COUNT_TOP;
         acc_sat = 1'b1;
      end else begin
         acc_count = n_new[COUNT_W-1:0];
      end
      s_new = acc_sum + s_add;
      if (s_new > SUM_HI) begin
         s_new = SUM_HI;
         acc_sat = 1'b1;
      end
      if (s_new < SUM_LO) begin
         s_new = SUM_LO;
         acc_sat = 1'b1;
      end
      acc_sum = s_new;
      q_new = {1'b0, acc_sum_sq} + {1'b0, q_add};
      if (q_new[SUM_SQ_W]) begin
         acc_sum_sq = '1;
         acc_sat = 1'b1;
      end else begin
         acc_sum_sq = q_new[SUM_SQ_W-1:0];
      end
   endtask

   // updates the accumulator for one accepted word; a report queues its expected result
   task automatic absorb_word(input req_word_type w);
      longint v, mn, mx, mag;
      rsp_word_type r;
      case (w.operation)
         OP_ADD: begin
            v = {{(64 - SAMPLE_W){w.sample[SAMPLE_W-1]}}, w.sample};
            if (v < acc_min) acc_min = v;
            if (v > acc_max) acc_max = v;
            mag = (v < 0) ? -v : v;
            accumulate((COUNT_W+1)'(1), v, mag * mag);
         end
         OP_MERGE: begin
            mn = {{(64 - SAMPLE_W){w.other_min[SAMPLE_W-1]}}, w.other_min};
            mx = {{(64 - SAMPLE_W){w.other_max[SAMPLE_W-1]}}, w.other_max};
            if (mn < acc_min) acc_min = mn;
            if (mx > acc_max) acc_max = mx;
            accumulate({1'b0, w.other_count},
                       {{(64 - SUM_W){w.other_sum[SUM_W-1]}}, w.other_sum}, w.other_sum_sq);
         end
         OP_REPORT: begin
            r.std_dev      = deviation_of(acc_count, acc_sum, acc_sum_sq);
            r.min_value    = acc_min[SAMPLE_W-1:0];
            r.max_value    = acc_max[SAMPLE_W-1:0];
            r.sample_count = acc_count;
            r.total_sum    = acc_sum[SUM_W-1:0];
            r.total_sum_sq = acc_sum_sq;
            r.stats_valid  = (acc_count != 0);
            r.saturated    = acc_sat;
            pending_reports.push_back(r);
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string field_name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field_name, want, got);
      end
   endtask

   task automatic compare_result(input rsp_word_type got);
      rsp_word_type want;
      if (pending_reports.size() == 0) begin
         errors++;
         $display("%0t: result word with nothing expected: expected none, actual %h",
                  $time, got);
         return;
      end
      want = pending_reports.pop_front();
      check_field("std_dev", 64'(want.std_dev), 64'(got.std_dev));
      check_field("min_value", 64'(want.min_value), 64'(got.min_value));
      check_field("max_value", 64'(want.max_value), 64'(got.max_value));
      check_field("sample_count", 64'(want.sample_count), 64'(got.sample_count));
      check_field("total_sum", 64'(want.total_sum), 64'(got.total_sum));
      check_field("total_sum_sq", want.total_sum_sq, got.total_sum_sq);
      check_field("stats_valid", 64'(want.stats_valid), 64'(got.stats_valid));
      check_field("saturated", 64'(want.saturated), 64'(got.saturated));
   endtask

   // request driver: predicts on acceptance, then offers the next word or idles
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.payload.operation == OP_REPORT) reports_in++;
            absorb_word(req_ch.payload);
            words_in++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (words_to_send.size() != 0 &&
                ((words_in >= 150 && words_in < 260) || $urandom_range(99) >= 14)) begin
               req_ch.valid <= 1'b1;
               req_ch.payload <= words_to_send.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: checks each accepted word, stalls at random, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            compare_result(rsp_ch.payload);
            results_seen++;
            if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= (results_seen >= 30 && results_seen < 45) ||
                            $urandom_range(99) >= 14;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                  pending_reports.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      int start, target, bound, len, k;
      longint smp, part_sum, mn, mx;
      logic [SUM_SQ_W-1:0] part_sq;
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;

      words_to_send.push_back(scrambled(OP_REPORT));   // empty accumulator
      words_to_send.push_back(scrambled(OP_UNUSED));
      words_to_send.push_back(merge_word(0, 0, 0, 100, -100)); // min/max taken with no count
      words_to_send.push_back(scrambled(OP_REPORT));
      words_to_send.push_back(add_word(1234));
      words_to_send.push_back(scrambled(OP_REPORT));   // one sample, zero spread
      words_to_send.push_back(add_word(-1));
      words_to_send.push_back(add_word(0));
      words_to_send.push_back(add_word(1));
      words_to_send.push_back(add_word(-4096));
      words_to_send.push_back(add_word(4096));
      words_to_send.push_back(scrambled(OP_REPORT));
      words_to_send.push_back(merge_word(3, 3 * 4096, 64'(3 * 4096 * 4096), -8192, 8192));
      words_to_send.push_back(scrambled(OP_REPORT));
      // big sum with no squares: variance goes negative
      words_to_send.push_back(merge_word(1, longint'(1) <<< 30, 0, 0, 0));
      words_to_send.push_back(scrambled(OP_REPORT));
      words_to_send.push_back(merge_word(0, -(longint'(1) <<< 30), 0, 0, 0));
      words_to_send.push_back(scrambled(OP_UNUSED));
      words_to_send.push_back(scrambled(OP_REPORT));

      // random part: mostly sample runs closed by a report, sample range widens over time
      start = words_to_send.size();
      target = start + RANDOM_WORDS;
      while (words_to_send.size() < target) begin
         bound = 1 << (8 + 14 * (words_to_send.size() - start) / RANDOM_WORDS);
         if ($urandom_range(99) < 85) begin
            len = $urandom_range(1, 8);
            repeat (len) begin
               if ($urandom_range(4) == 0) begin
                  // partial totals built from real samples
                  k = $urandom_range(0, 6);
                  part_sum = 0;
                  part_sq = '0;
                  mn = SAMPLE_HI;
                  mx = SAMPLE_LO;
                  repeat (k) begin
                     smp = longint'($urandom_range(2 * bound - 1)) - bound;
                     part_sum += smp;
                     part_sq += smp * smp;
                     if (smp < mn) mn = smp;
                     if (smp > mx) mx = smp;
                  end
                  words_to_send.push_back(merge_word(k, part_sum, part_sq, mn, mx));
               end else begin
                  words_to_send.push_back(
                     add_word(longint'($urandom_range(2 * bound - 1)) - bound));
               end
            end
            words_to_send.push_back(scrambled(OP_REPORT));
         end else begin
            case ($urandom_range(2))
               0: words_to_send.push_back(scrambled(OP_UNUSED));
               1: words_to_send.push_back(merge_word(
                     $urandom_range(15), longint'(int'($urandom)) >>> $urandom_range(4),
                     64'($urandom) << $urandom_range(8),
                     longint'($urandom_range(2 * bound - 1)) - bound,
                     longint'($urandom_range(2 * bound - 1)) - bound));
               default: words_to_send.push_back(scrambled(OP_REPORT));
            endcase
         end
      end

      // extremes and saturation last, since they stick
      words_to_send.push_back(add_word(SAMPLE_HI));
      words_to_send.push_back(add_word(SAMPLE_LO));
      words_to_send.push_back(scrambled(OP_REPORT));
      words_to_send.push_back(merge_word(1, 0, 64'h8000_0000_0000_0000, 0, 0));
      words_to_send.push_back(scrambled(OP_REPORT));   // deviation past the output range
      words_to_send.push_back(merge_word(0, SUM_HI, 0, 0, 0));
      words_to_send.push_back(merge_word(0, SUM_HI, 0, 0, 0));
      words_to_send.push_back(scrambled(OP_REPORT));
      words_to_send.push_back(merge_word(0, SUM_LO, 0, 0, 0));
      words_to_send.push_back(merge_word(0, SUM_LO, 0, 0, 0));
      words_to_send.push_back(scrambled(OP_REPORT));
      words_to_send.push_back(merge_word(0, 0, '1, 0, 0));
      words_to_send.push_back(scrambled(OP_REPORT));
      words_to_send.push_back(merge_word(COUNT_TOP, 0, 0, 0, 0));
      words_to_send.push_back(scrambled(OP_REPORT));
      words_to_send.push_back(add_word(5));
      words_to_send.push_back(scrambled(OP_REPORT));
      total_words = words_to_send.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (words_in != total_words || pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request words (%0d reports), compared %0d result words.",
               words_in, reports_in, results_seen);
      $display("Covered empty and single-sample reports, count-free merges, the unused code,");
      $display("deviation clamp, and saturation of count, sum and sum of squares.");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
